@@ hdl/fvrp_pkg.sv @@
`timescale 1ns / 1ps

package fvrp_pkg;

   // Printable ASCII window and the characters the record grammar uses.
   localparam logic [7:0] CHAR_LOW  = 8'h20;
   localparam logic [7:0] CHAR_HIGH = 8'h7E;
   localparam logic [7:0] CHAR_F    = 8'h46;
   localparam logic [7:0] CHAR_P    = 8'h50;
   localparam logic [7:0] CHAR_V    = 8'h56;
   localparam logic [7:0] CHAR_K    = 8'h6B;
   localparam logic [7:0] CHAR_EQ   = 8'h3D;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   // Character positions within a record; the opening letter sits at position 0.
   localparam int EQ_POS        = 1;
   localparam int F_K_POS       = 8;
   localparam int P_MIN_V_POS   = 3;
   localparam int P_MAX_V_POS   = 5;
   localparam int VOLT_LAST_POS = 4;

   localparam int FREQ_W = 48;
   localparam int VOLT_W = 24;
   localparam int RSP_W  = FREQ_W + VOLT_W;

   localparam int TOK_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      TOK_START_F,
      TOK_START_P,
      TOK_CHAR
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   ch;
   } tok_type;

   typedef enum logic {
      REC_F,
      REC_P
   } rec_kind_type;

   function automatic logic is_digit(input logic [7:0] c);
      logic res;
      res = c inside {[CHAR_ZERO:CHAR_NINE]};
      return res;
   endfunction

endpackage

@@ hdl/fvrp_fifo.sv @@
`timescale 1ns / 1ps

// Small first-in first-out queue; DEPTH must be a power of two.
module fvrp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/fvrp_front.sv @@
`timescale 1ns / 1ps

// Drops command and non-printable bytes and tags the rest for the parser.
module fvrp_front (
   input  logic              req_push,
   input  logic [7:0]        req_data_byte,
   input  logic              req_data_mode,
   output logic              req_full,
   output logic              tok_push,
   output fvrp_pkg::tok_type tok_data,
   input  logic              tok_full
);

   logic keep;

   assign req_full = tok_full;
   assign keep     = req_data_mode &&
                     (req_data_byte inside {[fvrp_pkg::CHAR_LOW:fvrp_pkg::CHAR_HIGH]});
   assign tok_push = req_push && !tok_full && keep;

   always_comb begin
      tok_data.ch = req_data_byte;
      case (req_data_byte)
         fvrp_pkg::CHAR_F: tok_data.kind = fvrp_pkg::TOK_START_F;
         fvrp_pkg::CHAR_P: tok_data.kind = fvrp_pkg::TOK_START_P;
         default:          tok_data.kind = fvrp_pkg::TOK_CHAR;
      endcase
   end

endmodule

@@ hdl/fvrp_back.sv @@
`timescale 1ns / 1ps

// Record parser: checks each character as it arrives and keeps only what a result needs.
module fvrp_back #(
   parameter int STORE_DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fvrp_pkg::tok_type          tok_data,
   input  logic                       tok_empty,
   output logic                       tok_pop,
   output logic                       res_push,
   output logic [fvrp_pkg::RSP_W-1:0] res_data,
   input  logic                       res_full
);

   localparam int CW = $clog2(STORE_DEPTH + 1);

   logic [CW-1:0]                 fill_ff, fill_in;
   fvrp_pkg::rec_kind_type        kind_ff, kind_in;
   logic                          ok_ff, ok_in;
   logic [fvrp_pkg::FREQ_W-1:0]   freq_acc_ff, freq_acc_in;
   logic [fvrp_pkg::VOLT_W-1:0]   volt_acc_ff, volt_acc_in;
   logic [fvrp_pkg::FREQ_W-1:0]   freq_hold_ff, freq_hold_in;
   logic                          pending_ff, pending_in;
   logic [7:0]                    c;
   logic                          open_room;

   assign c         = tok_data.ch;
   assign tok_pop   = !tok_empty && !res_full;
   assign open_room = (fill_ff != '0) && (fill_ff < CW'(STORE_DEPTH));
   assign res_data  = {freq_hold_ff, volt_acc_ff};

   always_comb begin
      fill_in      = fill_ff;
      kind_in      = kind_ff;
      ok_in        = ok_ff;
      freq_acc_in  = freq_acc_ff;
      volt_acc_in  = volt_acc_ff;
      freq_hold_in = freq_hold_ff;
      pending_in   = pending_ff;
      res_push     = 1'b0;
      if (tok_pop) begin
         case (tok_data.kind)
            fvrp_pkg::TOK_START_F: begin
               fill_in = CW'(1);
               kind_in = fvrp_pkg::REC_F;
               ok_in   = 1'b1;
            end
            fvrp_pkg::TOK_START_P: begin
               fill_in     = CW'(1);
               kind_in     = fvrp_pkg::REC_P;
               ok_in       = 1'b1;
               volt_acc_in = {3{fvrp_pkg::CHAR_ZERO}};
            end
            fvrp_pkg::TOK_CHAR: begin
               if (open_room) begin
                  fill_in = fill_ff + 1'b1;
                  if (kind_ff == fvrp_pkg::REC_F) begin
                     if (fill_ff == CW'(fvrp_pkg::EQ_POS)) begin
                        ok_in = ok_ff && (c == fvrp_pkg::CHAR_EQ);
                     end else if (fill_ff == CW'(fvrp_pkg::F_K_POS)) begin
                        if (ok_ff && (c == fvrp_pkg::CHAR_K)) begin
                           freq_hold_in = freq_acc_ff;
                           pending_in   = 1'b1;
                        end
                        fill_in = '0;
                     end else begin
                        ok_in       = ok_ff && (fvrp_pkg::is_digit(c) ||
                                               (c == fvrp_pkg::CHAR_DOT));
                        freq_acc_in = {freq_acc_ff[fvrp_pkg::FREQ_W-9:0], c};
                     end
                  end else begin
                     if (fill_ff == CW'(fvrp_pkg::EQ_POS)) begin
                        ok_in = ok_ff && (c == fvrp_pkg::CHAR_EQ);
                     end else if ((c == fvrp_pkg::CHAR_V) &&
                                  (fill_ff >= CW'(fvrp_pkg::P_MIN_V_POS))) begin
                        // Voltages longer than three digits are discarded.
                        if (ok_ff && (fill_ff <= CW'(fvrp_pkg::P_MAX_V_POS)) && pending_ff) begin
                           res_push   = 1'b1;
                           pending_in = 1'b0;
                        end
                        fill_in = '0;
                     end else begin
                        ok_in = ok_ff && fvrp_pkg::is_digit(c);
                        if (fill_ff <= CW'(fvrp_pkg::VOLT_LAST_POS)) begin
                           volt_acc_in = {volt_acc_ff[fvrp_pkg::VOLT_W-9:0], c};
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         kind_ff    <= fvrp_pkg::REC_F;
         pending_ff <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         kind_ff    <= kind_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff        <= ok_in;
      freq_acc_ff  <= freq_acc_in;
      volt_acc_ff  <= volt_acc_in;
      freq_hold_ff <= freq_hold_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(STORE_DEPTH))
      else $error("record fill count beyond store depth");

   a_push_needs_pending: assert property (@(posedge clock) disable iff (reset)
      res_push |-> (pending_ff && tok_pop && !res_full))
      else $error("result pushed without a pending frequency or a consumed token");

   a_pending_clears_on_emit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(pending_ff)) |-> $past(res_push))
      else $error("pending frequency dropped without a result");

   a_pending_sets_on_f: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(pending_ff)) |-> $past(kind_ff == fvrp_pkg::REC_F))
      else $error("pending frequency set outside an F record");

endmodule

@@ hdl/freq_volt_record_parser.sv @@
`timescale 1ns / 1ps

// An accepted request byte is registered in the token queue, and a result that it completes
// is registered in the result queue before it shows on the rsp_ ports. Throughput: one
// request per cycle while the result queue is not full. Two-entry queues sit between the byte
// filter and the parser and after the parser. Reset is synchronous and active high: it empties
// both queues, closes any open record and clears the pending frequency.
module freq_volt_record_parser #(
   parameter int STORE_DEPTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [7:0]                  req_data_byte,
   input  logic                        req_data_mode,
   input  logic                        req_last_of_transfer,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [fvrp_pkg::FREQ_W-1:0] rsp_freq_chars,
   output logic [fvrp_pkg::VOLT_W-1:0] rsp_volt_chars
);

   // The transfer boundary marker is carried on the interface, but the record grammar
   // does not depend on it, so it is accepted and otherwise not looked at.

   localparam int TOK_W = $bits(fvrp_pkg::tok_type);

   logic                       tok_push;
   logic                       tok_full;
   logic                       tok_empty;
   logic                       tok_pop;
   fvrp_pkg::tok_type          tok_in;
   fvrp_pkg::tok_type          tok_out;
   logic [TOK_W-1:0]           tok_out_bits;
   logic                       res_push;
   logic                       res_full;
   logic [fvrp_pkg::RSP_W-1:0] res_data;
   logic [fvrp_pkg::RSP_W-1:0] rsp_data;

   // The front end discards command bytes and anything outside printable ASCII,
   // and marks the two letters that open a record.
   fvrp_front u_front (
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_data_mode (req_data_mode),
      .req_full      (req_full),
      .tok_push      (tok_push),
      .tok_data      (tok_in),
      .tok_full      (tok_full)
   );

   fvrp_fifo #(
      .WIDTH (TOK_W),
      .DEPTH (fvrp_pkg::TOK_QUEUE_DEPTH)
   ) u_tok_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tok_push),
      .push_data (tok_in),
      .full      (tok_full),
      .pop       (tok_pop),
      .pop_data  (tok_out_bits),
      .empty     (tok_empty)
   );

   assign tok_out = fvrp_pkg::tok_type'(tok_out_bits);

   // The back end follows the open record character by character. Rather than storing the
   // whole record, it keeps a running validity flag, the six frequency characters and the
   // first three voltage digits, which is all a result ever needs.
   fvrp_back #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_data  (tok_out),
      .tok_empty (tok_empty),
      .tok_pop   (tok_pop),
      .res_push  (res_push),
      .res_data  (res_data),
      .res_full  (res_full)
   );

   // The result queue lets the parser keep going while a finished request waits to be taken.
   fvrp_fifo #(
      .WIDTH (fvrp_pkg::RSP_W),
      .DEPTH (fvrp_pkg::RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

   assign rsp_freq_chars = rsp_data[fvrp_pkg::RSP_W-1:fvrp_pkg::VOLT_W];
   assign rsp_volt_chars = rsp_data[fvrp_pkg::VOLT_W-1:0];

endmodule
